@@ rtl/ir_code_learn_and_replay_top_defines.svh @@
// Assertion macros for the IR learning remote top level.
// Both expect clk and rst_n in scope.
`ifndef IR_CODE_LEARN_AND_REPLAY_TOP_DEFINES_SVH
`define IR_CODE_LEARN_AND_REPLAY_TOP_DEFINES_SVH

// same-cycle implication
`define IRCLR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IRCLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/irclr_pkg.sv @@
package irclr_pkg;

    localparam int IRC_NUM_MODES     = 3;
    localparam int IRC_NUM_CODES     = 14;
    localparam int IRC_MAX_EDGES     = 255;
    localparam logic [15:0] FIRST_PERIOD_RESET = 16'd640;

    localparam logic [4:0] KEY_OK    = 5'd1;
    localparam logic [4:0] KEY_COPY  = 5'd2;
    localparam int         KEY_CODE0 = 3;

    typedef enum logic [1:0] {
        ACT_MODE   = 2'd0,
        ACT_KEY    = 2'd1,
        ACT_EDGE   = 2'd2,
        ACT_PERIOD = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RX   = 2'd1,
        ST_TX   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_OK,
        KIND_COPY,
        KIND_CODE
    } key_kind_t;

    typedef enum logic [2:0] {
        CS_WAIT,
        CS_EXEC,
        CS_CNT_RD,
        CS_CNT_LD,
        CS_DECIDE,
        CS_TX_DATA,
        CS_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic take;
        logic mode_step;
        logic set_copy;
        logic clr_copy;
        logic go_idle;
        logic set_code;
        logic cnt_load;
        logic rx_start;
        logic tx_start;
        logic rx_edge;
        logic tx_step;
        logic tx_end;
        logic flag_no_code;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        action_t   action;
        key_kind_t key_kind;
        logic      copy;
        logic      is_rx;
        logic      is_tx;
        logic      cnt_zero;
        logic      cnt_full;
        logic      idx_lt_cnt;
        logic      out_free;
    } stat_t;

endpackage

@@ rtl/irclr_ctrl.sv @@
module irclr_ctrl
    import irclr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_WAIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != CS_WAIT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            CS_WAIT:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                state_next = CS_FINISH;
                case (stat.action)
                    ACT_MODE:
                    begin
                        if (!stat.is_tx)
                        begin
                            cmd.mode_step = 1'b1;
                            state_next    = CS_CNT_RD;
                        end
                    end
                    ACT_KEY:
                    begin
                        if (!stat.is_tx)
                        begin
                            case (stat.key_kind)
                                KIND_COPY: cmd.set_copy = 1'b1;
                                KIND_OK:   cmd.clr_copy = 1'b1;
                                KIND_CODE:
                                begin
                                    cmd.set_code = 1'b1;
                                    state_next   = CS_CNT_RD;
                                end
                                default:   cmd.go_idle = 1'b1;
                            endcase
                        end
                    end
                    ACT_EDGE:
                    begin
                        if (stat.is_rx && !stat.cnt_full)
                        begin
                            cmd.rx_edge = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (stat.is_tx)
                        begin
                            if (stat.idx_lt_cnt)
                            begin
                                // store read of the next interval lands next cycle
                                state_next = CS_TX_DATA;
                            end
                            else
                            begin
                                cmd.tx_end = 1'b1;
                            end
                        end
                    end
                endcase
            end
            CS_CNT_RD:
            begin
                state_next = CS_CNT_LD;
            end
            CS_CNT_LD:
            begin
                cmd.cnt_load = 1'b1;
                state_next   = (stat.action == ACT_KEY) ? CS_DECIDE : CS_FINISH;
            end
            CS_DECIDE:
            begin
                if (stat.copy)
                begin
                    cmd.rx_start = 1'b1;
                end
                else if (!stat.cnt_zero)
                begin
                    cmd.tx_start = 1'b1;
                end
                else
                begin
                    cmd.flag_no_code = 1'b1;
                end
                state_next = CS_FINISH;
            end
            CS_TX_DATA:
            begin
                cmd.tx_step = 1'b1;
                state_next  = CS_FINISH;
            end
            CS_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = CS_WAIT;
                end
            end
            default:
            begin
                state_next = CS_WAIT;
            end
        endcase
    end

endmodule

@@ rtl/irclr_datapath.sv @@
module irclr_datapath
    import irclr_pkg::*;
#(
    parameter int NUM_MODES = IRC_NUM_MODES,
    parameter int NUM_CODES = IRC_NUM_CODES,
    parameter int MAX_EDGES = IRC_MAX_EDGES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic [1:0]  action,
    input  logic [4:0]  key_number,
    input  logic [15:0] edge_time,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  appliance_mode,
    output logic        copy_active,
    output logic [1:0]  link_status,
    output logic        ir_level,
    output logic [15:0] next_period,
    output logic        replay_done,
    output logic        no_code,
    output logic [7:0]  edge_count
);

    localparam int MODE_W    = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
    localparam int CODE_W    = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
    localparam int NUM_SLOTS = NUM_MODES * NUM_CODES;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SPAN      = MAX_EDGES + 1;
    localparam int CNT_W     = $clog2(SPAN);
    localparam int DEPTH     = NUM_SLOTS * SPAN;
    localparam int ADDR_W    = $clog2(DEPTH);

    // latched transaction
    action_t     action_reg;
    logic [4:0]  key_reg;
    logic [15:0] time_reg;

    // control state
    logic [15:0]       first_period_reg;
    logic [MODE_W-1:0] mode_reg,       mode_next;
    logic              copy_reg,       copy_next;
    status_t           status_reg,     status_next;
    logic [CODE_W-1:0] code_reg,       code_next;
    logic [CNT_W-1:0]  cur_count_reg,  cur_count_next;
    logic [CNT_W-1:0]  replay_idx_reg, replay_idx_next;
    logic [15:0]       last_edge_reg,  last_edge_next;
    logic              level_reg,      level_next;
    logic [15:0]       period_reg,     period_next;
    logic              done_reg,       done_next;
    logic              no_code_reg,    no_code_next;
    logic              out_valid_reg;

    // result payload
    logic [1:0]  out_mode_reg;
    logic        out_copy_reg;
    logic [1:0]  out_status_reg;
    logic        out_level_reg;
    logic [15:0] out_period_reg;
    logic        out_done_reg;
    logic        out_no_code_reg;
    logic [7:0]  out_count_reg;

    // slot count memory with reset-cleared valid flags
    logic [CNT_W-1:0]     cnt_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] cnt_vld_reg;
    logic [CNT_W-1:0]     cnt_rd_reg;
    logic                 cnt_rd_vld_reg;
    logic                 cnt_we;
    logic [CNT_W-1:0]     cnt_wdata;

    // interval store
    logic [15:0]       store_mem [DEPTH];
    logic [15:0]       store_rd_reg;
    logic [ADDR_W-1:0] slot_base;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    logic [SLOT_W-1:0] slot_idx;
    logic [CNT_W-1:0]  cnt_inc;
    logic [6:0]        key_ext;
    logic [6:0]        key_off;
    key_kind_t         key_kind;

    assign key_ext = 7'(key_reg);
    assign key_off = key_ext - 7'(KEY_CODE0);

    always_comb
    begin
        if (key_reg == KEY_OK)
        begin
            key_kind = KIND_OK;
        end
        else if (key_reg == KEY_COPY)
        begin
            key_kind = KIND_COPY;
        end
        else if (key_ext >= 7'(KEY_CODE0) && key_ext < 7'(KEY_CODE0 + NUM_CODES))
        begin
            key_kind = KIND_CODE;
        end
        else
        begin
            key_kind = KIND_NONE;
        end
    end

    assign slot_idx  = SLOT_W'(mode_reg) * SLOT_W'(NUM_CODES) + SLOT_W'(code_reg);
    assign slot_base = ADDR_W'(slot_idx) * ADDR_W'(SPAN);
    assign wr_addr   = slot_base + ADDR_W'(cur_count_reg);
    assign rd_addr   = slot_base + ADDR_W'(replay_idx_reg);
    assign cnt_inc   = cur_count_reg + CNT_W'(1);

    assign cnt_we    = cmd.rx_start | cmd.rx_edge;
    assign cnt_wdata = cmd.rx_edge ? cnt_inc : '0;

    always_comb
    begin
        stat.action     = action_reg;
        stat.key_kind   = key_kind;
        stat.copy       = copy_reg;
        stat.is_rx      = (status_reg == ST_RX);
        stat.is_tx      = (status_reg == ST_TX);
        stat.cnt_zero   = (cur_count_reg == '0);
        stat.cnt_full   = (cur_count_reg >= CNT_W'(MAX_EDGES));
        stat.idx_lt_cnt = (replay_idx_reg < cur_count_reg);
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        mode_next       = mode_reg;
        copy_next       = copy_reg;
        status_next     = status_reg;
        code_next       = code_reg;
        cur_count_next  = cur_count_reg;
        replay_idx_next = replay_idx_reg;
        last_edge_next  = last_edge_reg;
        level_next      = level_reg;
        period_next     = period_reg;
        done_next       = done_reg;
        no_code_next    = no_code_reg;

        if (cmd.take)
        begin
            period_next  = '0;
            done_next    = 1'b0;
            no_code_next = 1'b0;
        end
        if (cmd.mode_step)
        begin
            mode_next   = (mode_reg == MODE_W'(NUM_MODES - 1)) ? '0 : mode_reg + MODE_W'(1);
            copy_next   = 1'b0;
            status_next = ST_IDLE;
        end
        if (cmd.set_copy)
        begin
            copy_next   = 1'b1;
            status_next = ST_IDLE;
        end
        if (cmd.clr_copy)
        begin
            copy_next   = 1'b0;
            status_next = ST_IDLE;
        end
        if (cmd.go_idle)
        begin
            status_next = ST_IDLE;
        end
        if (cmd.set_code)
        begin
            code_next = key_off[CODE_W-1:0];
        end
        if (cmd.cnt_load)
        begin
            cur_count_next = cnt_rd_vld_reg ? cnt_rd_reg : '0;
        end
        if (cmd.rx_start)
        begin
            cur_count_next = '0;
            last_edge_next = '0;
            status_next    = ST_RX;
        end
        if (cmd.tx_start)
        begin
            status_next     = ST_TX;
            replay_idx_next = CNT_W'(1);
            level_next      = 1'b0;
            period_next     = first_period_reg;
        end
        if (cmd.flag_no_code)
        begin
            status_next  = ST_IDLE;
            no_code_next = 1'b1;
        end
        if (cmd.rx_edge)
        begin
            last_edge_next = time_reg;
            cur_count_next = cnt_inc;
        end
        if (cmd.tx_step)
        begin
            level_next      = ~level_reg;
            period_next     = store_rd_reg;
            replay_idx_next = replay_idx_reg + CNT_W'(1);
        end
        if (cmd.tx_end)
        begin
            status_next     = ST_IDLE;
            replay_idx_next = CNT_W'(1);
            level_next      = 1'b0;
            done_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_period_reg <= FIRST_PERIOD_RESET;
            mode_reg         <= '0;
            copy_reg         <= 1'b0;
            status_reg       <= ST_IDLE;
            code_reg         <= '0;
            cur_count_reg    <= '0;
            replay_idx_reg   <= CNT_W'(1);
            last_edge_reg    <= '0;
            level_reg        <= 1'b0;
            period_reg       <= '0;
            done_reg         <= 1'b0;
            no_code_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            cnt_vld_reg      <= '0;
            cnt_rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                first_period_reg <= cfg_wr_data;
            end
            mode_reg       <= mode_next;
            copy_reg       <= copy_next;
            status_reg     <= status_next;
            code_reg       <= code_next;
            cur_count_reg  <= cur_count_next;
            replay_idx_reg <= replay_idx_next;
            last_edge_reg  <= last_edge_next;
            level_reg      <= level_next;
            period_reg     <= period_next;
            done_reg       <= done_next;
            no_code_reg    <= no_code_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cnt_we)
            begin
                cnt_vld_reg[slot_idx] <= 1'b1;
            end
            cnt_rd_vld_reg <= cnt_vld_reg[slot_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            action_reg <= action_t'(action);
            key_reg    <= key_number;
            time_reg   <= edge_time;
        end
        if (cmd.out_load)
        begin
            out_mode_reg    <= 2'(mode_reg);
            out_copy_reg    <= copy_reg;
            out_status_reg  <= status_reg;
            out_level_reg   <= level_reg;
            out_period_reg  <= period_reg;
            out_done_reg    <= done_reg;
            out_no_code_reg <= no_code_reg;
            out_count_reg   <= 8'(cur_count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[slot_idx] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[slot_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rx_edge)
        begin
            store_mem[wr_addr] <= time_reg - last_edge_reg;
        end
        store_rd_reg <= store_mem[rd_addr];
    end

    assign out_valid      = out_valid_reg;
    assign appliance_mode = out_mode_reg;
    assign copy_active    = out_copy_reg;
    assign link_status    = out_status_reg;
    assign ir_level       = out_level_reg;
    assign next_period    = out_period_reg;
    assign replay_done    = out_done_reg;
    assign no_code        = out_no_code_reg;
    assign edge_count     = out_count_reg;

endmodule

@@ rtl/ir_code_learn_and_replay_top.sv @@
// One transaction at a time: from WAIT the control goes to EXEC, then FINISH for edges,
// ignored buttons, plain keys and the last period end, via TX_DATA for other period ends,
// via CNT_RD, CNT_LD for the mode button and also DECIDE for code keys, as the slot count
// memory and interval store are read through registers. The result is loaded as FINISH
// returns to WAIT for the next one; a stalled result holds the input off until it drains.
// Reset (async, active low) clears control state and slot counts (valid flags); 640 period.
`include "ir_code_learn_and_replay_top_defines.svh"

module ir_code_learn_and_replay_top
    import irclr_pkg::*;
#(
    parameter int NUM_MODES = IRC_NUM_MODES,
    parameter int NUM_CODES = IRC_NUM_CODES,
    parameter int MAX_EDGES = IRC_MAX_EDGES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [4:0]  key_number,
    input  logic [15:0] edge_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  appliance_mode,
    output logic        copy_active,
    output logic [1:0]  link_status,
    output logic        ir_level,
    output logic [15:0] next_period,
    output logic        replay_done,
    output logic        no_code,
    output logic [7:0]  edge_count
);

    cmd_t  cmd;
    stat_t stat;

    irclr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    irclr_datapath #(
        .NUM_MODES (NUM_MODES),
        .NUM_CODES (NUM_CODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .action         (action),
        .key_number     (key_number),
        .edge_time      (edge_time),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .appliance_mode (appliance_mode),
        .copy_active    (copy_active),
        .link_status    (link_status),
        .ir_level       (ir_level),
        .next_period    (next_period),
        .replay_done    (replay_done),
        .no_code        (no_code),
        .edge_count     (edge_count)
    );

    // only one transaction in flight
    `IRCLR_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second transaction taken while busy")

    // a period is only announced while transmitting
    `IRCLR_ASSERT_SAME(a_period_only_tx, out_valid && next_period != 16'd0, link_status == ST_TX, "next_period set outside replay")

    // learning mode and replay exclude each other
    `IRCLR_ASSERT_SAME(a_copy_not_tx, out_valid && copy_active, link_status != ST_TX, "replay running in copy mode")

    // finished replay or empty slot leaves the line idle and low
    `IRCLR_ASSERT_SAME(a_end_idle, out_valid && (replay_done || no_code), link_status == ST_IDLE && !ir_level, "replay end not idle")

endmodule

@@ tb/sv/ir_code_learn_and_replay_top_test.sv @@
`timescale 1ns / 1ps

module ir_code_learn_and_replay_top_test;
    import irclr_pkg::*;

    localparam int NUM_SLOTS = IRC_NUM_MODES * IRC_NUM_CODES;
    localparam int RANDOM_ITEMS = 950;
    localparam int DIRECTED_ITEMS = 27;
    localparam int NUM_PHASES = 4;
    localparam logic [4:0] KEY_DEAD_LOW = 5'd0;
    localparam logic [4:0] KEY_DEAD_HIGH = 5'd31;

    typedef struct packed {
        action_t     act;
        logic [4:0]  key;
        logic [15:0] etime;
    } remote_event_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        copy;
        logic [1:0]  status;
        logic        level;
        logic [15:0] period;
        logic        done;
        logic        no_code;
        logic [7:0]  edges;
    } remote_out_t;

    class ir_remote_tracker;
        logic [15:0] first_period;
        logic [1:0]  mode;
        logic        copy_on;
        status_t     status;
        int          code;
        int          edge_counts [NUM_SLOTS];
        logic [15:0] intervals [NUM_SLOTS][IRC_MAX_EDGES + 1];
        int          replay_pos;
        logic [15:0] last_edge;
        logic        level;
        remote_out_t expected_status [$];
        int          failures;

        function new();
            first_period = FIRST_PERIOD_RESET;
            mode = '0;
            copy_on = 1'b0;
            status = ST_IDLE;
            code = 0;
            foreach (edge_counts[i])
                edge_counts[i] = 0;
            replay_pos = 1;
            last_edge = '0;
            level = 1'b0;
            failures = 0;
        endfunction

        function int slot_now();
            return int'(mode) * IRC_NUM_CODES + code;
        endfunction

        function bit transmitting();
            return status == ST_TX;
        endfunction

        function int outstanding();
            return expected_status.size();
        endfunction

        function void press_key(input logic [4:0] key, inout remote_out_t o);
            int s;
            if (key == KEY_COPY)
            begin
                copy_on = 1'b1;
                status = ST_IDLE;
            end
            else if (key == KEY_OK)
            begin
                copy_on = 1'b0;
                status = ST_IDLE;
            end
            else if (int'(key) >= KEY_CODE0 && int'(key) < KEY_CODE0 + IRC_NUM_CODES)
            begin
                code = int'(key) - KEY_CODE0;
                s = slot_now();
                if (copy_on)
                begin
                    // capture timer restarts with the new slot
                    edge_counts[s] = 0;
                    last_edge = '0;
                    status = ST_RX;
                end
                else if (edge_counts[s] > 0)
                begin
                    status = ST_TX;
                    replay_pos = 1;
                    level = 1'b0;
                    o.period = first_period;
                end
                else
                begin
                    status = ST_IDLE;
                    o.no_code = 1'b1;
                end
            end
            else
            begin
                status = ST_IDLE;
            end
        endfunction

        // Advances the remote by one accepted transaction and queues the status it reports
        function void note_event(remote_event_t ev);
            remote_out_t o;
            int s;
            o = '0;
            s = slot_now();
            case (ev.act)
                ACT_MODE:
                    if (status != ST_TX)
                    begin
                        copy_on = 1'b0;
                        status = ST_IDLE;
                        mode = (int'(mode) == IRC_NUM_MODES - 1) ? 2'd0 : mode + 2'd1;
                    end
                ACT_KEY:
                    if (status != ST_TX)
                        press_key(ev.key, o);
                ACT_EDGE:
                    if (status == ST_RX && edge_counts[s] < IRC_MAX_EDGES)
                    begin
                        intervals[s][edge_counts[s]] = ev.etime - last_edge;
                        last_edge = ev.etime;
                        edge_counts[s]++;
                    end
                default:
                    if (status == ST_TX)
                    begin
                        if (replay_pos < edge_counts[s])
                        begin
                            level = ~level;
                            o.period = intervals[s][replay_pos];
                            replay_pos++;
                        end
                        else
                        begin
                            status = ST_IDLE;
                            replay_pos = 1;
                            level = 1'b0;
                            o.done = 1'b1;
                        end
                    end
            endcase
            o.mode = mode;
            o.copy = copy_on;
            o.status = status;
            o.level = level;
            o.edges = 8'(edge_counts[slot_now()]);
            expected_status.push_back(o);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_status_word(remote_out_t got);
            remote_out_t want;
            if (expected_status.size() == 0)
            begin
                $error("status word with no transaction outstanding");
                failures++;
                return;
            end
            want = expected_status.pop_front();
            compare_field("appliance_mode", want.mode, got.mode);
            compare_field("copy_active", want.copy, got.copy);
            compare_field("link_status", want.status, got.status);
            compare_field("ir_level", want.level, got.level);
            compare_field("next_period", want.period, got.period);
            compare_field("replay_done", want.done, got.done);
            compare_field("no_code", want.no_code, got.no_code);
            compare_field("edge_count", want.edges, got.edges);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    action_t     action;
    logic [4:0]  key_number;
    logic [15:0] edge_time;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  appliance_mode;
    logic        copy_active;
    logic [1:0]  link_status;
    logic        ir_level;
    logic [15:0] next_period;
    logic        replay_done;
    logic        no_code;
    logic [7:0]  edge_count;

    ir_remote_tracker tracker = new();
    int items_sent = 0;
    int in_calm = 0;
    int stall_calm = 0;
    int last_code = 0;

    ir_code_learn_and_replay_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .key_number     (key_number),
        .edge_time      (edge_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .appliance_mode (appliance_mode),
        .copy_active    (copy_active),
        .link_status    (link_status),
        .ir_level       (ir_level),
        .next_period    (next_period),
        .replay_done    (replay_done),
        .no_code        (no_code),
        .edge_count     (edge_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int pick_gap(ref int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(40, 150);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [4:0] code_key(int c);
        return 5'(KEY_CODE0 + c);
    endfunction

    // entered and left at a falling edge
    task automatic send_item(action_t a, logic [4:0] k, logic [15:0] t);
        remote_event_t ev;
        int gap;
        gap = pick_gap(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= a;
        key_number <= k;
        edge_time <= t;
        ev.act = a;
        ev.key = k;
        ev.etime = t;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_event(ev);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_noise(bit no_period);
        action_t a;
        a = action_t'(no_period ? $urandom_range(0, 2) : $urandom_range(0, 3));
        send_item(a, 5'($urandom_range(0, 31)), 16'($urandom));
    endtask

    task automatic capture_sequence(int n_edges, bit clean);
        logic [15:0] t;
        int c;
        c = $urandom_range(0, IRC_NUM_CODES - 1);
        if (!clean && $urandom_range(0, 3) == 0)
            send_item(ACT_MODE, 5'($urandom_range(0, 31)), 16'($urandom));
        send_item(ACT_KEY, KEY_COPY, 16'($urandom));
        send_item(ACT_KEY, code_key(c), 16'($urandom));
        last_code = c;
        t = 16'($urandom);
        repeat (n_edges)
        begin
            if (!clean && $urandom_range(0, 19) == 0)
                send_noise(1'b0);
            if ($urandom_range(0, 3) == 0)
                t = 16'($urandom);
            else
                t = t + 16'($urandom_range(1, 4000));
            send_item(ACT_EDGE, 5'($urandom_range(0, 31)), t);
        end
        if (clean)
            send_item(ACT_KEY, KEY_OK, 16'($urandom));
        else
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_item(ACT_KEY, KEY_OK, 16'($urandom));
                6, 7: send_item(ACT_MODE, 5'($urandom_range(0, 31)), 16'($urandom));
                default: send_item(ACT_KEY, 5'($urandom_range(0, 31)), 16'($urandom));
            endcase
    endtask

    task automatic replay_sequence(bit same_slot);
        int c;
        c = (same_slot || $urandom_range(0, 3) != 0) ? last_code
                                                      : $urandom_range(0, IRC_NUM_CODES - 1);
        send_item(ACT_KEY, KEY_OK, 16'($urandom));
        send_item(ACT_KEY, code_key(c), 16'($urandom));
        while (tracker.transmitting())
        begin
            if (!same_slot && $urandom_range(0, 9) == 0)
                send_noise(1'b1);
            else
                send_item(ACT_PERIOD, 5'($urandom_range(0, 31)), 16'($urandom));
        end
        repeat ($urandom_range(0, 2))
            send_item(ACT_PERIOD, 5'($urandom_range(0, 31)), 16'($urandom));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        // a little slack before the register write
        repeat (10) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_first_period(logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tracker.first_period = v;
    endtask

    task automatic directed_items();
        send_item(ACT_KEY, KEY_DEAD_LOW, 16'h0000);
        send_item(ACT_KEY, KEY_DEAD_HIGH, 16'hFFFF);
        // stray edge and stray period end while idle
        send_item(ACT_EDGE, KEY_DEAD_HIGH, 16'hFFFF);
        send_item(ACT_PERIOD, KEY_DEAD_LOW, 16'h0000);
        // empty slot
        send_item(ACT_KEY, code_key(IRC_NUM_CODES - 1), 16'h0000);
        send_item(ACT_KEY, KEY_COPY, 16'h0000);
        send_item(ACT_KEY, code_key(0), 16'h0000);
        send_item(ACT_EDGE, KEY_DEAD_LOW, 16'h0000);
        send_item(ACT_EDGE, KEY_DEAD_LOW, 16'hFFFF);
        send_item(ACT_EDGE, KEY_DEAD_LOW, 16'h0005);
        send_item(ACT_EDGE, KEY_DEAD_LOW, 16'h1234);
        send_item(ACT_PERIOD, KEY_DEAD_LOW, 16'h0000);
        send_item(ACT_KEY, KEY_OK, 16'h0000);
        send_item(ACT_KEY, code_key(0), 16'h0000);
        // buttons and edges during replay are ignored
        send_item(ACT_MODE, KEY_DEAD_LOW, 16'h0000);
        send_item(ACT_KEY, KEY_COPY, 16'h0000);
        send_item(ACT_EDGE, KEY_DEAD_LOW, 16'hABCD);
        repeat (4)
            send_item(ACT_PERIOD, KEY_DEAD_LOW, 16'h0000);
        // mode button ends a capture and keeps its count
        send_item(ACT_KEY, KEY_COPY, 16'h0000);
        send_item(ACT_KEY, code_key(IRC_NUM_CODES - 1), 16'h0000);
        send_item(ACT_EDGE, KEY_DEAD_LOW, 16'h8000);
        send_item(ACT_MODE, KEY_DEAD_LOW, 16'h0000);
        send_item(ACT_MODE, KEY_DEAD_LOW, 16'h0000);
        send_item(ACT_MODE, KEY_DEAD_LOW, 16'h0000);
    endtask

    initial
    begin : stimulus
        int r;
        int target;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        action = ACT_MODE;
        key_number = '0;
        edge_time = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_items();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_idle();
                case (phase)
                    1: set_first_period(16'h0000);
                    2: set_first_period(16'hFFFF);
                    default: set_first_period(16'($urandom));
                endcase
            end
            if (phase == 1)
            begin
                // fills a slot past its limit, then plays it all back
                capture_sequence(IRC_MAX_EDGES + 5, 1'b1);
                replay_sequence(1'b1);
            end
            target = DIRECTED_ITEMS + RANDOM_ITEMS * (phase + 1) / NUM_PHASES;
            while (items_sent < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    capture_sequence($urandom_range(1, 12), 1'b0);
                else if (r < 75)
                    replay_sequence(1'b0);
                else
                    repeat ($urandom_range(1, 6))
                        send_noise(1'b0);
            end
        end

        wait_idle();
        if (tracker.failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stall_driver
        int hold;
        hold = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
            end
            else if (out_stall)
            begin
                out_stall <= 1'b0;
                hold = $urandom_range(0, 5);
            end
            else
            begin
                hold = pick_gap(stall_calm);
                if (hold > 0)
                begin
                    out_stall <= 1'b1;
                    hold--;
                end
                else
                begin
                    hold = $urandom_range(0, 5);
                end
            end
        end
    end

    always @(posedge clk)
    begin : status_monitor
        remote_out_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.mode = appliance_mode;
            got.copy = copy_active;
            got.status = link_status;
            got.level = ir_level;
            got.period = next_period;
            got.done = replay_done;
            got.no_code = no_code;
            got.edges = edge_count;
            tracker.check_status_word(got);
        end
    end

    initial
    begin : watchdog
        #(10_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/irclr_pkg.sv
rtl/irclr_ctrl.sv
rtl/irclr_datapath.sv
rtl/ir_code_learn_and_replay_top.sv
tb/sv/ir_code_learn_and_replay_top_test.sv
